// ----- src/ptrs_pkg.sv -----
// Shared types and constants for the periodic task release scheduler.
// Used by ptrs_ctrl, ptrs_dp and the top level; depends on nothing.
package ptrs_pkg;

    localparam int TASKS_DEFAULT = 4;
    localparam int FIELD_TASKS   = 4;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;

    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [7:0]  TICKS_RESET  = 8'd1;

    // register index, taken from paddr[4:2]
    localparam logic [2:0] REG_TICKS   = 3'd0;
    localparam logic [2:0] REG_COUNT   = 3'd1;
    localparam logic [2:0] REG_PERIOD0 = 3'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic tick;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic ticks_done;
        logic out_busy;
    } t_dp_status;

endpackage

// ----- src/periodic_task_release_scheduler_unit.sv -----
// Top level of the periodic task release scheduler: APB register file,
// controller and datapath. Depends on ptrs_pkg, ptrs_ctrl and ptrs_dp.
//
// Each accepted word applies suspend then enable to the runnable bits of the
// tasks in use, then counts ticks_per_cycle ticks, one tick per clock, with all
// task phase counters stepping in parallel on each tick. A word passes through
// the tick loop, then the check that sees the tick counter reach zero, then
// the load of the output register, which waits while the output side stalls
// a previous result. The next word is accepted the cycle after the result is
// loaded, while that result may still wait in the output register.
// Registers: 0 ticks_per_cycle, 1 task_count, 2..5 period of tasks 0..3, at
// byte address 4*index.
module periodic_task_release_scheduler_unit #(
    parameter int NUM_TASKS = ptrs_pkg::TASKS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptrs_pkg::ADDR_W-1:0] paddr,
    input  logic [ptrs_pkg::DATA_W-1:0] pwdata,
    output logic [ptrs_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [3:0]                  i_suspend_mask,
    input  logic [3:0]                  i_enable_mask,
    input  logic [3:0]                  i_busy_mask,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [3:0]                  o_trigger_mask,
    output logic [3:0]                  o_overrun_mask,
    output logic                        o_overrun_flag,
    output logic [31:0]                 o_elapsed_ticks
);
    import ptrs_pkg::*;

    localparam int PERIOD_REGS = (NUM_TASKS < FIELD_TASKS) ? NUM_TASKS : FIELD_TASKS;

    logic [7:0]                 r_ticks;
    logic [2:0]                 r_task_count;
    logic [15:0]                r_period [PERIOD_REGS];
    logic [NUM_TASKS-1:0][15:0] w_period;
    logic [NUM_TASKS-1:0]       w_used_mask;
    logic [2:0]                 w_index;
    logic                       w_wr;
    t_dp_cmd                    w_cmd;
    t_dp_status                 w_status;

    assign pready  = 1'b1;
    assign w_index = paddr[4:2];
    assign w_wr    = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks      <= TICKS_RESET;
            r_task_count <= '0;
            for (int t = 0; t < PERIOD_REGS; t++) r_period[t] <= PERIOD_RESET;
        end else if (w_wr) begin
            case (w_index)
                REG_TICKS: r_ticks      <= pwdata[7:0];
                REG_COUNT: r_task_count <= pwdata[2:0];
                default: ;
            endcase
            for (int t = 0; t < PERIOD_REGS; t++) begin
                if (w_index == REG_PERIOD0 + 3'(t)) r_period[t] <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        case (w_index)
            REG_TICKS: prdata = {24'd0, r_ticks};
            REG_COUNT: prdata = {29'd0, r_task_count};
            default:   prdata = '0;
        endcase
        for (int t = 0; t < PERIOD_REGS; t++) begin
            if (w_index == REG_PERIOD0 + 3'(t)) prdata = {16'd0, r_period[t]};
        end
    end

    // tasks without a period register keep the reset period
    for (genvar j = 0; j < NUM_TASKS; j++) begin : g_task
        if (j < PERIOD_REGS) begin : g_reg
            assign w_period[j] = r_period[j];
        end else begin : g_fixed
            assign w_period[j] = PERIOD_RESET;
        end
        assign w_used_mask[j] = (32'(r_task_count) > j);
    end

    ptrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ptrs_dp #(
        .NUM_TASKS (NUM_TASKS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_ticks_per_cycle (r_ticks),
        .i_used_mask       (w_used_mask),
        .i_period          (w_period),
        .i_suspend_mask    (i_suspend_mask),
        .i_enable_mask     (i_enable_mask),
        .i_busy_mask       (i_busy_mask),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_trigger_mask    (o_trigger_mask),
        .o_overrun_mask    (o_overrun_mask),
        .o_overrun_flag    (o_overrun_flag),
        .o_elapsed_ticks   (o_elapsed_ticks)
    );

endmodule

// ----- src/ptrs_ctrl.sv -----
// Controller of the scheduler: accepts a word, runs the tick loop, then
// hands the result to the output register. Depends on ptrs_pkg.
module ptrs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ptrs_pkg::t_dp_status i_status,
    output ptrs_pkg::t_dp_cmd    o_cmd
);
    import ptrs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_TICK;
            end
            ST_TICK: begin
                if (i_status.ticks_done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!i_status.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.start  = i_in_valid;
            end
            ST_TICK: begin
                o_cmd.tick   = !i_status.ticks_done;
            end
            ST_FINISH: begin
                o_cmd.finish = !i_status.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

    a_tick_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK && i_status.ticks_done) |=> (r_state == ST_FINISH))
        else $error("tick loop did not end in finish");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_TICK))
        else $error("start did not enter tick loop");

endmodule

// ----- src/ptrs_dp.sv -----
// Datapath of the scheduler: runnable bits, per-task phase counters, tick
// counter, trigger accumulation and the output register. Depends on ptrs_pkg.
module ptrs_dp #(
    parameter int NUM_TASKS = ptrs_pkg::TASKS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ptrs_pkg::t_dp_cmd            i_cmd,
    output ptrs_pkg::t_dp_status         o_status,
    input  logic [7:0]                  i_ticks_per_cycle,
    input  logic [NUM_TASKS-1:0]        i_used_mask,
    input  logic [NUM_TASKS-1:0][15:0]  i_period,
    input  logic [3:0]                  i_suspend_mask,
    input  logic [3:0]                  i_enable_mask,
    input  logic [3:0]                  i_busy_mask,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [3:0]                  o_trigger_mask,
    output logic [3:0]                  o_overrun_mask,
    output logic                        o_overrun_flag,
    output logic [31:0]                 o_elapsed_ticks
);
    import ptrs_pkg::*;

    logic [NUM_TASKS-1:0]   r_runnable;
    logic [NUM_TASKS-1:0]   r_trig;
    logic [NUM_TASKS-1:0]   w_fire;
    logic [NUM_TASKS-1:0]   w_suspend;
    logic [NUM_TASKS-1:0]   w_enable;
    logic [15:0]            r_phase [NUM_TASKS];
    logic [15:0]            n_phase [NUM_TASKS];
    logic [7:0]             r_tick_cnt;
    logic [3:0]             r_busy;
    logic [31:0]            r_tick_total;
    logic                   r_sticky;
    logic [3:0]             w_trig4;
    logic [3:0]             w_over;
    logic                   r_out_valid;

    // widen the 4-bit fields to the task count; tasks beyond the fields see zero
    for (genvar j = 0; j < NUM_TASKS; j++) begin : g_ext
        if (j < FIELD_TASKS) begin : g_in
            assign w_suspend[j] = i_suspend_mask[j];
            assign w_enable[j]  = i_enable_mask[j];
        end else begin : g_out
            assign w_suspend[j] = 1'b0;
            assign w_enable[j]  = 1'b0;
        end
    end

    for (genvar j = 0; j < FIELD_TASKS; j++) begin : g_trig
        if (j < NUM_TASKS) begin : g_have
            assign w_trig4[j] = r_trig[j];
        end else begin : g_none
            assign w_trig4[j] = 1'b0;
        end
    end

    assign w_over = w_trig4 & r_busy;

    // one tick of every phase counter
    always_comb begin
        logic [15:0] p1;
        for (int j = 0; j < NUM_TASKS; j++) begin
            p1         = r_phase[j] + 16'd1;
            w_fire[j]  = 1'b0;
            n_phase[j] = p1;
            if (i_period[j] == 16'd0) begin
                n_phase[j] = 16'd0;
            end else if (p1 >= i_period[j]) begin
                n_phase[j] = 16'd0;
                w_fire[j]  = i_used_mask[j] & r_runnable[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_runnable   <= '1;
            r_tick_cnt   <= '0;
            r_tick_total <= '0;
            r_sticky     <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int j = 0; j < NUM_TASKS; j++) r_phase[j] <= '0;
        end else begin
            if (i_cmd.start) begin
                // suspend first, enable wins
                r_runnable <= (r_runnable & ~(w_suspend & i_used_mask))
                              | (w_enable & i_used_mask);
                r_tick_cnt <= i_ticks_per_cycle;
            end
            if (i_cmd.tick) begin
                r_tick_cnt <= r_tick_cnt - 8'd1;
                for (int j = 0; j < NUM_TASKS; j++) r_phase[j] <= n_phase[j];
            end
            if (i_cmd.finish) begin
                r_tick_total <= r_tick_total + 32'(i_ticks_per_cycle);
                if (|w_over) r_sticky <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_trig <= '0;
            r_busy <= i_busy_mask;
        end else if (i_cmd.tick) begin
            r_trig <= r_trig | w_fire;
        end
        if (i_cmd.finish) begin
            o_trigger_mask  <= w_trig4;
            o_overrun_mask  <= w_over;
            o_overrun_flag  <= r_sticky | (|w_over);
            o_elapsed_ticks <= r_tick_total + 32'(i_ticks_per_cycle);
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status.ticks_done = (r_tick_cnt == 8'd0);
    assign o_status.out_busy   = r_out_valid & i_out_stall;

    a_over_in_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((o_overrun_mask & ~o_trigger_mask) == 4'd0))
        else $error("overrun without trigger");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (o_overrun_mask != 4'd0)) |-> o_overrun_flag)
        else $error("overrun flag not set");

    a_tick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick |=> (r_tick_cnt == $past(r_tick_cnt) - 8'd1))
        else $error("tick counter did not step");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !(r_out_valid && i_out_stall))
        else $error("output register overwritten while stalled");

endmodule
